// ===== design/tpm_pkg.sv =====
// shared types and constants for the typed phrase matcher
// no dependencies
package tpm_pkg;

  localparam int WINDOW_CHARS = 60;
  localparam int MAX_PHRASE   = 30;
  localparam int PHRASE_SLOTS = 16;
  localparam int SLOT_CHARS   = MAX_PHRASE - 1;
  localparam int KEEP_CHARS   = (MAX_PHRASE + 1 < WINDOW_CHARS - 3) ? MAX_PHRASE + 1
                                                                    : WINDOW_CHARS - 3;
  localparam int TRIM_AT      = WINDOW_CHARS - 2;
  localparam int TRIM_SHIFT   = TRIM_AT - KEEP_CHARS;
  localparam int SLOT_AW      = 4;
  localparam int POS_AW       = 5;
  localparam int MEM_AW       = SLOT_AW + POS_AW;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TYPE  = 2'd1,
    OP_BACK  = 2'd2,
    OP_ENTER = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_END,
    S_DONE
  } state_t;

  localparam logic [2:0] REG_ENTER_CLEARS = 3'd0;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] typed_char;
    logic [3:0] phrase_slot;
    logic [4:0] phrase_pos;
    logic [7:0] phrase_char;
  } in_item_t;

  typedef struct packed {
    logic       match_found;
    logic [3:0] match_slot;
    logic [5:0] window_length;
  } out_item_t;

  // shared controls broadcast to every window cell
  typedef struct packed {
    logic       step;
    logic       first;
    logic [7:0] scan_char;
    logic [7:0] wr_char;
    logic       trim;
  } cell_ctl_t;

endpackage

// ===== design/tpm_cell.sv =====
// one window cell: holds a typed character and a running prefix match flag
// depends on tpm_pkg
module tpm_cell (
  input  logic               clk,
  input  logic               rst,
  input  tpm_pkg::cell_ctl_t ctl,
  input  logic               wr_sel,
  input  logic [7:0]         trim_src,
  input  logic               left_flag,
  input  logic               active,
  output logic [7:0]         ch,
  output logic               flag
);
  import tpm_pkg::*;

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      ch <= ctl.wr_char;
    end else if (ctl.trim) begin
      ch <= trim_src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctl.step) begin
      flag <= (ctl.first | left_flag) & (ch == ctl.scan_char) & active;
    end
  end

endmodule

// ===== design/tpm_phrase_ram.sv =====
// phrase store memory, one write and one registered read port
// depends on tpm_pkg
module tpm_phrase_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tpm_pkg::MEM_AW-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [tpm_pkg::MEM_AW-1:0] raddr,
  output logic [7:0]                 rdata
);
  import tpm_pkg::*;

  logic [7:0] mem [2**MEM_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/typed_phrase_matcher_top.sv =====
// typed phrase matcher top: fsm, window cell chain, phrase store, apb register
// depends on tpm_pkg, tpm_cell, tpm_phrase_ram
// sequence: load transactions go through S_DONE to the output register; edits read and compare
//   each stored phrase character (S_READ, S_CMP), then end each slot with a terminator read,
//   or S_END for a full slot, all through the single phrase read port
// throughput: one transaction at a time, next accepted the cycle after the result is registered
// reset: synchronous; a clearing pass over all 512 entries zeroes the phrase store,
//   no transaction is accepted until it ends; enter_clears resets to 1
module typed_phrase_matcher_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpm_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tpm_pkg::*;

  state_t state, state_next;

  logic                enter_clears;
  logic [5:0]          len;
  logic [SLOT_AW-1:0]  slot;
  logic [POS_AW-1:0]   k;
  logic                found;
  logic [SLOT_AW-1:0]  which;
  logic [MEM_AW-1:0]   clr_addr;

  logic                accept;
  logic [7:0]          lower_char;
  logic                do_trim;
  logic [5:0]          wr_pos;
  logic [7:0]          rdata;
  logic                any_flag;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;
  cell_ctl_t           ctl;

  logic [7:0]          cell_ch   [WINDOW_CHARS];
  logic [WINDOW_CHARS-1:0] cell_flag;

  // apb register port, always ready
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ENTER_CLEARS) ? {31'd0, enter_clears} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_clears <= 1'b1;
    end else if (psel && penable && pwrite && paddr == REG_ENTER_CLEARS) begin
      enter_clears <= pwdata[0];
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // typed character prep: lowercase letters, trim the window once it holds TRIM_AT characters
  assign lower_char = (in_data.typed_char >= 8'h41 && in_data.typed_char <= 8'h5a)
                      ? in_data.typed_char + 8'd32 : in_data.typed_char;
  assign do_trim    = accept && in_data.opcode == OP_TYPE && len >= 6'(TRIM_AT);
  assign wr_pos     = do_trim ? 6'(KEEP_CHARS) : len;

  // phrase store writes: clearing pass after reset, then loads
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 8'd0;
    end else begin
      mem_we    = accept && in_data.opcode == OP_LOAD
                  && in_data.phrase_pos < 5'(SLOT_CHARS);
      mem_waddr = {in_data.phrase_slot, in_data.phrase_pos};
      mem_wdata = in_data.phrase_char;
    end
  end

  tpm_phrase_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr ({slot, k}),
    .rdata (rdata)
  );

  // broadcast controls for the cell chain
  always_comb begin
    ctl.step      = (state == S_CMP) && rdata != 8'd0;
    ctl.first     = (k == '0);
    ctl.scan_char = rdata;
    ctl.wr_char   = lower_char;
    ctl.trim      = do_trim;
  end

  // each cell takes the flag of its left neighbor, cell 0 sees none
  for (genvar i = 0; i < WINDOW_CHARS; i++) begin : g_cell
    logic [7:0] trim_src;
    logic       left_flag;
    if (i + TRIM_SHIFT < WINDOW_CHARS) begin : g_src
      assign trim_src = cell_ch[i + TRIM_SHIFT];
    end else begin : g_nosrc
      assign trim_src = 8'd0;
    end
    if (i == 0) begin : g_head
      assign left_flag = 1'b0;
    end else begin : g_body
      assign left_flag = cell_flag[i-1];
    end
    tpm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_sel    (accept && in_data.opcode == OP_TYPE && wr_pos == 6'(i)),
      .trim_src  (trim_src),
      .left_flag (left_flag),
      .active    (6'(i) < len),
      .ch        (cell_ch[i]),
      .flag      (cell_flag[i])
    );
  end

  assign any_flag = |cell_flag;

  // sequencer: walk slots, reading (S_READ) and comparing (S_CMP) one phrase character at a time
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) state_next = (in_data.opcode == OP_LOAD) ? S_DONE : S_READ;
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (rdata == 8'd0) begin
          if ((k != '0 && any_flag) || slot == SLOT_AW'(PHRASE_SLOTS - 1)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end else if (k == POS_AW'(SLOT_CHARS - 1)) begin
          state_next = S_END;
        end else begin
          state_next = S_READ;
        end
      end
      S_END: begin
        if (any_flag || slot == SLOT_AW'(PHRASE_SLOTS - 1)) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // window length, slot walk and match capture
  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      slot  <= '0;
      k     <= '0;
      found <= 1'b0;
      which <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            slot  <= '0;
            k     <= '0;
            found <= 1'b0;
            which <= '0;
            case (in_data.opcode)
              OP_TYPE:  len <= wr_pos + 6'd1;
              OP_BACK:  if (len != '0) len <= len - 6'd1;
              OP_ENTER: if (enter_clears) len <= '0;
              default:  len <= len;
            endcase
          end
        end
        S_CMP: begin
          if (rdata == 8'd0) begin
            if (k != '0 && any_flag) begin
              found <= 1'b1;
              which <= slot;
              len   <= '0;
            end else begin
              slot <= slot + 1'b1;
              k    <= '0;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_END: begin
          if (any_flag) begin
            found <= 1'b1;
            which <= slot;
            len   <= '0;
          end else begin
            slot <= slot + 1'b1;
            k    <= '0;
          end
        end
        default: len <= len;
      endcase
    end
  end

  // output register, holds its transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.match_found   <= found;
      out_data.match_slot    <= which;
      out_data.window_length <= len;
    end
  end

endmodule
